// File: rtl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg
// shared types and constants of the timed cue table tracker
// ----------------------------------------------------------------------------
package ctt_pkg;

    localparam int TIME_W   = 32;
    localparam int HANDLE_W = 16;
    localparam int KIND_W   = 3;
    localparam int DUR_W    = 23;

    localparam logic [TIME_W-1:0] TOTAL_RESET_MS = 32'd300000;
    localparam logic [TIME_W-1:0] CUE_TAIL_MS    = 32'd10000;
    localparam logic [9:0]        MS_PER_S       = 10'd1000;

    localparam logic [KIND_W-1:0] KIND_CUE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DUR   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESET = 3'd4;

    localparam logic RES_DISPLAY  = 1'b0;
    localparam logic RES_PROGRESS = 1'b1;

    typedef struct packed {
        logic                ins_en;
        logic                cmp_en;
        logic [TIME_W-1:0]   key;
        logic [HANDLE_W-1:0] handle;
    } cell_ctl_t;

    typedef struct packed {
        logic                kind;
        logic [HANDLE_W-1:0] current_handle;
        logic                has_next;
        logic [HANDLE_W-1:0] next_handle;
        logic [TIME_W-1:0]   elapsed_ms;
        logic [TIME_W-1:0]   total_ms;
        logic                last;
    } res_t;

endpackage

// File: rtl/ctt_cell.sv
// ----------------------------------------------------------------------------
// ctt_cell
// one table slot: holds a cue, shifts right on insertion, flags the last
// cue at or before a query time
// ----------------------------------------------------------------------------
module ctt_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctt_pkg::cell_ctl_t            ctl,
    input  logic                          occupied,
    input  logic                          at_end,
    input  logic                          left_gt,
    input  logic [ctt_pkg::TIME_W-1:0]    left_time,
    input  logic [ctt_pkg::HANDLE_W-1:0]  left_handle,
    input  logic                          left_hit,
    input  logic                          right_le,
    output logic                          gt,
    output logic                          le,
    output logic [ctt_pkg::TIME_W-1:0]    cue_time,
    output logic [ctt_pkg::HANDLE_W-1:0]  cue_handle,
    output logic                          hit,
    output logic [ctt_pkg::HANDLE_W-1:0]  sel_handle,
    output logic                          nxt_valid,
    output logic [ctt_pkg::HANDLE_W-1:0]  nxt_handle
);
    import ctt_pkg::*;

    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   time_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] handle_next;
    logic                hit_reg;
    logic                hit_next;

    assign gt = occupied && (time_reg > ctl.key);
    assign le = occupied && (time_reg <= ctl.key);

    always_comb
    begin
        time_next   = time_reg;
        handle_next = handle_reg;
        hit_next    = hit_reg;
        if (ctl.ins_en && (gt || at_end))
        begin
            time_next   = left_gt ? left_time   : ctl.key;
            handle_next = left_gt ? left_handle : ctl.handle;
        end
        if (ctl.cmp_en)
        begin
            hit_next = le && !right_le;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg   <= time_next;
        handle_reg <= handle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign cue_time   = time_reg;
    assign cue_handle = handle_reg;
    assign hit        = hit_reg;
    assign sel_handle = hit_reg ? handle_reg : '0;
    assign nxt_valid  = left_hit && occupied;
    assign nxt_handle = nxt_valid ? handle_reg : '0;

endmodule

// File: rtl/ctt_res_queue.sv
// ----------------------------------------------------------------------------
// ctt_res_queue
// four-entry result queue, takes up to two words per cycle, gives one
// ----------------------------------------------------------------------------
module ctt_res_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_a,
    input  logic          push_b,
    input  ctt_pkg::res_t data_a,
    input  ctt_pkg::res_t data_b,
    input  logic          pop,
    output ctt_pkg::res_t head,
    output logic [2:0]    count
);
    import ctt_pkg::*;

    res_t       entry_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [1:0] n_push;

    assign n_push = {1'b0, push_a} + {1'b0, push_b};

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        cnt_next    = cnt_reg + {1'b0, n_push} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
        begin
            entry_reg[wr_ptr_reg] <= data_a;
        end
        if (push_b)
        begin
            entry_reg[wr_ptr_reg + 2'd1] <= data_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = cnt_reg;

endmodule

// File: rtl/timed_cue_table_tracker_unit.sv
// ----------------------------------------------------------------------------
// timed_cue_table_tracker_unit
// sorted table of timed cues in a row of cells, playback position tracking
//
// channel  | handshake            | words
// ---------+----------------------+---------------------------------------
// in       | in_valid / in_stall  | kind, cue time, flags, handle, clock, duration
// out      | out_valid / out_stall| display change or progress report
//
// cue: on accept, plus a display state when the first cue of a song is shown;
// tick: compare in each cell, then select across the row; others: on accept
// insertion shifts the whole row in parallel, one slot per cell
// results wait in a four-word queue; in_stall rises while fewer than two
// free words remain or a cue or tick is still in work
// reset clears control state at once; no table sweep is needed
// ----------------------------------------------------------------------------
module timed_cue_table_tracker_unit #(
    parameter int CUE_DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ctt_pkg::KIND_W-1:0]    kind,
    input  logic [ctt_pkg::TIME_W-1:0]    cue_time_ms,
    input  logic                          has_time,
    input  logic                          has_text,
    input  logic [ctt_pkg::HANDLE_W-1:0]  text_handle,
    input  logic [ctt_pkg::TIME_W-1:0]    now_ms,
    input  logic [ctt_pkg::DUR_W-1:0]     duration_s,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          result_kind,
    output logic [ctt_pkg::HANDLE_W-1:0]  current_handle,
    output logic                          has_next,
    output logic [ctt_pkg::HANDLE_W-1:0]  next_handle,
    output logic [ctt_pkg::TIME_W-1:0]    elapsed_ms,
    output logic [ctt_pkg::TIME_W-1:0]    total_ms_out,
    output logic                          last
);
    import ctt_pkg::*;

    localparam int ADDR_W = $clog2(CUE_DEPTH);
    localparam int CNT_W  = $clog2(CUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CUE_SHOW,
        ST_TK_CMP,
        ST_TK_SEL
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                shown_valid_reg;
    logic                shown_valid_next;
    logic [ADDR_W-1:0]   shown_idx_reg;
    logic [ADDR_W-1:0]   shown_idx_next;
    logic                running_reg;
    logic                running_next;
    logic [TIME_W-1:0]   start_reg;
    logic [TIME_W-1:0]   start_next;
    logic [TIME_W-1:0]   total_reg;
    logic [TIME_W-1:0]   total_next;
    logic                locked_reg;
    logic                locked_next;
    logic [TIME_W-1:0]   el_reg;
    logic [TIME_W-1:0]   el_next;

    logic                in_acc;
    logic                pop;
    logic [2:0]          q_count;
    logic                push_a;
    logic                push_b;
    res_t                res_a;
    res_t                res_b;
    res_t                head;
    cell_ctl_t           ctl;

    logic [TIME_W-1:0]   t_eff;
    logic [TIME_W:0]     tail_sum;
    logic [TIME_W-1:0]   tail_sat;
    logic [TIME_W:0]     dur_prod;
    logic [TIME_W-1:0]   dur_sat;
    logic [TIME_W-1:0]   el_raw;

    logic                gt_w       [CUE_DEPTH];
    logic                le_w       [CUE_DEPTH];
    logic [TIME_W-1:0]   time_w     [CUE_DEPTH];
    logic [HANDLE_W-1:0] handle_w   [CUE_DEPTH];
    logic                hit_w      [CUE_DEPTH];
    logic [HANDLE_W-1:0] sel_h_w    [CUE_DEPTH];
    logic                nxt_v_w    [CUE_DEPTH];
    logic [HANDLE_W-1:0] nxt_h_w    [CUE_DEPTH];

    logic                found;
    logic [ADDR_W-1:0]   found_idx;
    logic [HANDLE_W-1:0] found_handle;
    logic                found_has_next;
    logic [HANDLE_W-1:0] found_next;
    logic [CUE_DEPTH-1:0] hit_vec;

    // row of cells
    for (genvar i = 0; i < CUE_DEPTH; i++)
    begin : g_cell
        logic                occ;
        logic                endp;
        logic                l_gt;
        logic [TIME_W-1:0]   l_time;
        logic [HANDLE_W-1:0] l_handle;
        logic                l_hit;
        logic                r_le;

        assign occ  = CNT_W'(i) < cnt_reg;
        assign endp = CNT_W'(i) == cnt_reg;

        if (i == 0)
        begin : g_first
            assign l_gt     = 1'b0;
            assign l_time   = '0;
            assign l_handle = '0;
            assign l_hit    = 1'b0;
        end
        else
        begin : g_mid
            assign l_gt     = gt_w[i-1];
            assign l_time   = time_w[i-1];
            assign l_handle = handle_w[i-1];
            assign l_hit    = hit_w[i-1];
        end

        if (i == CUE_DEPTH - 1)
        begin : g_last
            assign r_le = 1'b0;
        end
        else
        begin : g_inner
            assign r_le = le_w[i+1];
        end

        ctt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .occupied    (occ),
            .at_end      (endp),
            .left_gt     (l_gt),
            .left_time   (l_time),
            .left_handle (l_handle),
            .left_hit    (l_hit),
            .right_le    (r_le),
            .gt          (gt_w[i]),
            .le          (le_w[i]),
            .cue_time    (time_w[i]),
            .cue_handle  (handle_w[i]),
            .hit         (hit_w[i]),
            .sel_handle  (sel_h_w[i]),
            .nxt_valid   (nxt_v_w[i]),
            .nxt_handle  (nxt_h_w[i])
        );

        assign hit_vec[i] = hit_w[i];
    end

    // select across the row from the registered hit flags
    always_comb
    begin
        found          = 1'b0;
        found_idx      = '0;
        found_handle   = '0;
        found_has_next = 1'b0;
        found_next     = '0;
        for (int i = 0; i < CUE_DEPTH; i++)
        begin
            found          = found | hit_w[i];
            found_idx      = found_idx | (hit_w[i] ? ADDR_W'(i) : '0);
            found_handle   = found_handle | sel_h_w[i];
            found_has_next = found_has_next | nxt_v_w[i];
            found_next     = found_next | nxt_h_w[i];
        end
    end

    assign in_stall = !((state_reg == ST_IDLE) && (q_count <= 3'd2));
    assign in_acc   = in_valid && !in_stall;

    assign t_eff    = has_time ? cue_time_ms : '0;
    assign tail_sum = {1'b0, t_eff} + {1'b0, CUE_TAIL_MS};
    assign tail_sat = tail_sum[TIME_W] ? '1 : tail_sum[TIME_W-1:0];
    assign dur_prod = {{(TIME_W + 1 - DUR_W){1'b0}}, duration_s}
                      * {{(TIME_W - 9){1'b0}}, MS_PER_S};
    assign dur_sat  = dur_prod[TIME_W] ? '1 : dur_prod[TIME_W-1:0];
    assign el_raw   = now_ms - start_reg;

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        shown_valid_next = shown_valid_reg;
        shown_idx_next   = shown_idx_reg;
        running_next     = running_reg;
        start_next       = start_reg;
        total_next       = total_reg;
        locked_next      = locked_reg;
        el_next          = el_reg;
        push_a           = 1'b0;
        push_b           = 1'b0;
        res_a            = '0;
        res_b            = '0;
        ctl.ins_en       = 1'b0;
        ctl.cmp_en       = 1'b0;
        ctl.key          = (state_reg == ST_IDLE) ? t_eff : el_reg;
        ctl.handle       = text_handle;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (kind)
                        KIND_CUE:
                        begin
                            if (has_time && !locked_reg && (tail_sat > total_reg))
                            begin
                                total_next = tail_sat;
                            end
                            if (has_text && (cnt_reg < CNT_W'(CUE_DEPTH)))
                            begin
                                ctl.ins_en = 1'b1;
                                cnt_next   = cnt_reg + 1'b1;
                            end
                            if (!running_reg)
                            begin
                                running_next = 1'b1;
                                start_next   = now_ms;
                                if ((cnt_reg != '0) || ctl.ins_en)
                                begin
                                    shown_valid_next = 1'b1;
                                    shown_idx_next   = '0;
                                    state_next       = ST_CUE_SHOW;
                                end
                            end
                        end
                        KIND_TICK:
                        begin
                            if (running_reg && (total_reg != '0))
                            begin
                                el_next    = (el_raw > total_reg) ? total_reg : el_raw;
                                state_next = ST_TK_CMP;
                            end
                        end
                        KIND_DUR:
                        begin
                            if (duration_s != '0)
                            begin
                                total_next  = dur_sat;
                                locked_next = 1'b1;
                            end
                        end
                        KIND_END, KIND_RESET:
                        begin
                            res_a.kind = RES_PROGRESS;
                            res_a.last = 1'b1;
                            if (kind == KIND_END)
                            begin
                                res_a.elapsed_ms = total_reg;
                                res_a.total_ms   = total_reg;
                                push_a           = total_reg != '0;
                            end
                            else
                            begin
                                push_a = 1'b1;
                            end
                            cnt_next         = '0;
                            shown_valid_next = 1'b0;
                            shown_idx_next   = '0;
                            running_next     = 1'b0;
                            start_next       = '0;
                            total_next       = TOTAL_RESET_MS;
                            locked_next      = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CUE_SHOW:
            begin
                push_a               = 1'b1;
                res_a.kind           = RES_DISPLAY;
                res_a.current_handle = handle_w[0];
                res_a.has_next       = cnt_reg > CNT_W'(1);
                res_a.next_handle    = (cnt_reg > CNT_W'(1)) ? handle_w[1] : '0;
                res_a.last           = 1'b1;
                state_next           = ST_IDLE;
            end
            ST_TK_CMP:
            begin
                ctl.cmp_en = 1'b1;
                state_next = ST_TK_SEL;
            end
            ST_TK_SEL:
            begin
                if (found && (!shown_valid_reg || (found_idx != shown_idx_reg)))
                begin
                    shown_valid_next     = 1'b1;
                    shown_idx_next       = found_idx;
                    push_a               = 1'b1;
                    res_a.kind           = RES_DISPLAY;
                    res_a.current_handle = found_handle;
                    res_a.has_next       = found_has_next;
                    res_a.next_handle    = found_next;
                    push_b               = 1'b1;
                    res_b.kind           = RES_PROGRESS;
                    res_b.elapsed_ms     = el_reg;
                    res_b.total_ms       = total_reg;
                    res_b.last           = 1'b1;
                end
                else
                begin
                    push_a           = 1'b1;
                    res_a.kind       = RES_PROGRESS;
                    res_a.elapsed_ms = el_reg;
                    res_a.total_ms   = total_reg;
                    res_a.last       = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            shown_valid_reg <= 1'b0;
            shown_idx_reg   <= '0;
            running_reg     <= 1'b0;
            start_reg       <= '0;
            total_reg       <= TOTAL_RESET_MS;
            locked_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            shown_valid_reg <= shown_valid_next;
            shown_idx_reg   <= shown_idx_next;
            running_reg     <= running_next;
            start_reg       <= start_next;
            total_reg       <= total_next;
            locked_reg      <= locked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        el_reg <= el_next;
    end

    ctt_res_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_a (push_a),
        .push_b (push_b),
        .data_a (res_a),
        .data_b (res_b),
        .pop    (pop),
        .head   (head),
        .count  (q_count)
    );

    assign out_valid      = q_count != 3'd0;
    assign pop            = out_valid && !out_stall;
    assign result_kind    = head.kind;
    assign current_handle = head.current_handle;
    assign has_next       = head.has_next;
    assign next_handle    = head.next_handle;
    assign elapsed_ms     = head.elapsed_ms;
    assign total_ms_out   = head.total_ms;
    assign last           = head.last;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CUE_DEPTH))
        else $error("cue count beyond table depth");

    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TK_SEL) |-> $onehot0(hit_vec))
        else $error("more than one cell claims the current cue");

    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (kind == KIND_TICK) && running_reg && (total_reg != '0))
        |=> (state_reg == ST_TK_CMP))
        else $error("tick did not start the cell compare");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= 3'd4)
        else $error("result queue overflow");

endmodule
